FILE: src/iida_pkg.sv
package iida_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int OP_W         = 2;
    localparam int POS_W        = 7;
    localparam int VAL_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 8;
    // number of cell taps folded into one register of the read tree
    localparam int GROUP_SIZE   = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_BAD_POSITION = 2'd1,
        ST_FULL         = 2'd2,
        ST_EMPTY        = 2'd3
    } t_status;

    // what every cell of the row does in this cycle
    typedef enum logic [2:0] {
        CM_HOLD   = 3'd0,
        CM_INSERT = 3'd1,
        CM_DELETE = 3'd2,
        CM_UPDATE = 3'd3,
        CM_READ   = 3'd4
    } t_cell_mode;

    typedef struct packed {
        logic              load;
        t_cell_mode        mode;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  value;
    } t_cell_ctl;

endpackage

FILE: src/iida_req_if.sv
interface iida_req_if import iida_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

FILE: src/iida_rsp_if.sv
interface iida_rsp_if import iida_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [VAL_W-1:0]  read_value;
    logic [COUNT_W-1:0]       count;

    modport source (output valid, output status, output read_value, output count, input ready);
    modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

FILE: src/indexed_insert_delete_array.sv
// channel   | dir | transaction payload                       | handshake
// ----------+-----+-------------------------------------------+------------
// i_req     | in  | op[1:0], position[6:0], value[31:0] signed | valid/ready
// o_rsp     | out | status[1:0], read_value[31:0], count[7:0]  | valid/ready
//
// one request is taken per clock while o_rsp is not stalled; its result passes the cell tap,
// the group register of the read tree and the output register before it is valid on o_rsp
// the row of cells shifts every affected entry at once on insert and delete
// i_rst_n (synchronous, active low) clears the count and the pipeline valid bits;
// the entries themselves are not cleared and only slots below the count are read
// a stalled o_rsp backs the pipeline up; i_req.ready drops once all stages are full and o_rsp stalls
module indexed_insert_delete_array import iida_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    iida_req_if.sink        i_req,
    iida_rsp_if.source      o_rsp
);

    // count must hold the capacity itself
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    // common width to compare position against count
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int N_GROUP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int N_PAD   = N_GROUP * GROUP_SIZE;

    // ---------------- request decode ----------------
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CMP_W-1:0]   w_pos_c;
    logic [CMP_W-1:0]   w_cnt_c;
    logic               w_full;
    logic               w_empty;
    t_op                w_op;
    t_status            w_status;
    t_cell_mode         w_mode;
    logic               w_acc;
    t_cell_ctl          w_ctl;

    assign w_op    = t_op'(i_req.op);
    assign w_pos_c = CMP_W'(i_req.position);
    assign w_cnt_c = CMP_W'(r_count);
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    // status check; full is tested ahead of the position on insert
    always_comb begin
        w_status = ST_OK;
        unique case (w_op)
            OP_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos_c > w_cnt_c) begin
                    w_status = ST_BAD_POSITION;
                end
            end
            OP_DELETE: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos_c >= w_cnt_c) begin
                    w_status = ST_BAD_POSITION;
                end
            end
            default: begin
                // update and read on an empty store land here as bad position
                if (w_pos_c >= w_cnt_c) begin
                    w_status = ST_BAD_POSITION;
                end
            end
        endcase
    end

    // refused requests leave the row alone
    always_comb begin
        w_mode = CM_HOLD;
        if (w_acc && w_status == ST_OK) begin
            unique case (w_op)
                OP_INSERT: w_mode = CM_INSERT;
                OP_DELETE: w_mode = CM_DELETE;
                OP_UPDATE: w_mode = CM_UPDATE;
                OP_READ:   w_mode = CM_READ;
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_mode == CM_INSERT) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_mode == CM_DELETE) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_ctl.load  = w_acc;
    assign w_ctl.mode  = w_mode;
    assign w_ctl.pos   = i_req.position;
    assign w_ctl.value = i_req.value;

    // ---------------- pipeline control ----------------
    logic               r_s1_v;
    t_status            r_s1_status;
    logic [COUNT_W-1:0] r_s1_count;
    logic               r_s2_v;
    t_status            r_s2_status;
    logic [COUNT_W-1:0] r_s2_count;
    logic               r_out_v;
    t_status            r_out_status;
    logic [COUNT_W-1:0] r_out_count;
    logic [VAL_W-1:0]   r_out_rd;
    logic [VAL_W-1:0]   w_rd;
    logic               w_take;
    logic               w_mv1;
    logic               w_mv2;

    assign w_take      = r_out_v && o_rsp.ready;
    assign w_mv2       = r_s2_v && (!r_out_v || w_take);
    assign w_mv1       = r_s1_v && (!r_s2_v || w_mv2);
    assign i_req.ready = !r_s1_v || w_mv1;
    assign w_acc       = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_s1_v <= 1'b1;
            end else if (w_mv1) begin
                r_s1_v <= 1'b0;
            end
            if (w_mv1) begin
                r_s2_v <= 1'b1;
            end else if (w_mv2) begin
                r_s2_v <= 1'b0;
            end
            if (w_mv2) begin
                r_out_v <= 1'b1;
            end else if (w_take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload side of the pipeline, no reset
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_status <= w_status;
            r_s1_count  <= COUNT_W'(n_count);
        end
        if (w_mv1) begin
            r_s2_status <= r_s1_status;
            r_s2_count  <= r_s1_count;
        end
        if (w_mv2) begin
            r_out_status <= r_s2_status;
            r_out_count  <= r_s2_count;
            r_out_rd     <= w_rd;
        end
    end

    // ---------------- row of cells ----------------
    logic [VAL_W-1:0] w_entry [CAPACITY];
    logic [VAL_W-1:0] w_tap   [N_PAD];
    logic [VAL_W-1:0] w_grp   [N_GROUP];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;

        // ends of the row see zero; those slots lie past the count anyway
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[i+1];
        end

        iida_cell #(
            .INDEX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[i]),
            .o_tap   (w_tap[i])
        );
    end

    // pad the read tree up to whole groups
    for (genvar p = CAPACITY; p < N_PAD; p++) begin : g_pad
        assign w_tap[p] = '0;
    end

    // ---------------- read tree ----------------
    iida_gather #(
        .N_GROUP (N_GROUP)
    ) u_gather (
        .i_clk  (i_clk),
        .i_load (w_mv1),
        .i_taps (w_tap),
        .o_grp  (w_grp)
    );

    // at most one tap is non-zero, so an or of the groups selects it
    always_comb begin
        w_rd = '0;
        for (int g = 0; g < N_GROUP; g++) begin
            w_rd = w_rd | w_grp[g];
        end
    end

    assign o_rsp.valid      = r_out_v;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.read_value = r_out_rd;
    assign o_rsp.count      = r_out_count;

    // ---------------- checks ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_op == OP_INSERT && w_status == ST_OK)
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("good insert did not grow the count");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_status != ST_OK) |=> r_count == $past(r_count))
        else $error("refused request changed the count");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_rd != '0) |-> r_out_status == ST_OK)
        else $error("non-zero read value on a refused request");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s2_v && r_out_v && !o_rsp.ready) |-> !i_req.ready)
        else $error("request taken while every stage is stalled");

endmodule

FILE: src/iida_cell.sv
module iida_cell import iida_pkg::*; #(
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [VAL_W-1:0]  i_left,
    input  logic [VAL_W-1:0]  i_right,
    output logic [VAL_W-1:0]  o_entry,
    output logic [VAL_W-1:0]  o_tap
);

    logic [VAL_W-1:0] r_entry;
    logic [VAL_W-1:0] n_entry;
    logic [VAL_W-1:0] r_tap;
    logic             w_hit;
    logic             w_above;

    assign w_hit   = (INDEX == int'(i_ctl.pos));
    assign w_above = (INDEX >  int'(i_ctl.pos));

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.mode)
            CM_INSERT: begin
                if (w_above) begin
                    n_entry = i_left;
                end else if (w_hit) begin
                    n_entry = i_ctl.value;
                end
            end
            CM_DELETE: begin
                if (w_above || w_hit) begin
                    n_entry = i_right;
                end
            end
            CM_UPDATE: begin
                if (w_hit) begin
                    n_entry = i_ctl.value;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctl.load) begin
            // tap is zero unless this cell is the one being read
            r_tap <= (i_ctl.mode == CM_READ && w_hit) ? r_entry : '0;
        end
    end

    assign o_entry = r_entry;
    assign o_tap   = r_tap;

endmodule

FILE: src/iida_gather.sv
module iida_gather import iida_pkg::*; #(
    parameter int N_GROUP = 4
) (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic [VAL_W-1:0]  i_taps [N_GROUP*GROUP_SIZE],
    output logic [VAL_W-1:0]  o_grp  [N_GROUP]
);

    logic [VAL_W-1:0] r_grp [N_GROUP];

    for (genvar g = 0; g < N_GROUP; g++) begin : g_grp
        logic [VAL_W-1:0] w_or;

        always_comb begin
            w_or = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                w_or = w_or | i_taps[g*GROUP_SIZE + k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_load) begin
                r_grp[g] <= w_or;
            end
        end

        assign o_grp[g] = r_grp[g];
    end

endmodule
